// File: design/pm_pkg.sv
// shared widths, op codes and controller/datapath interface structs
// for the polynomial multiply block; depends on nothing
package pm_pkg;

    localparam int OP_W      = 2;
    localparam int EXP_W     = 5;
    localparam int COEF_W    = 32;
    localparam int DEG_W     = 5;
    localparam int PEXP_W    = 6;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_LOAD_A   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B   = 2'd1;
    localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              store_clr;
        logic              acc_clr;
        logic              issue;
        logic [EXP_W-1:0]  addr_a;
        logic [EXP_W-1:0]  addr_b;
        logic              out_load;
        logic [PEXP_W-1:0] out_exp;
        logic              out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/pm_ctrl.sv
// sequencer for loads and the convolution walk over coefficient pairs
// depends on pm_pkg
module pm_ctrl #(
    parameter int MAX_TERMS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [pm_pkg::OP_W-1:0]  i_op,
    input  logic [pm_pkg::DEG_W-1:0] i_degree_a,
    input  logic [pm_pkg::DEG_W-1:0] i_degree_b,
    input  pm_pkg::t_dp_stat         i_stat,
    output pm_pkg::t_dp_cmd          o_cmd
);
    import pm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_TERMS - 1);

    t_state              r_state, n_state;
    logic [DEG_W-1:0]    r_da, n_da;
    logic [DEG_W-1:0]    r_db, n_db;
    logic [PEXP_W-1:0]   r_total, n_total;
    logic [PEXP_W-1:0]   r_k, n_k;
    logic [EXP_W-1:0]    r_i, n_i;

    logic [PEXP_W-1:0]   k_next;
    logic [PEXP_W-1:0]   i_lo_next;
    logic [PEXP_W-1:0]   i_hi;
    logic [DEG_W-1:0]    da_clamp, db_clamp;
    logic                accept;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign da_clamp = (i_degree_a > DEG_MAX) ? DEG_MAX : i_degree_a;
    assign db_clamp = (i_degree_b > DEG_MAX) ? DEG_MAX : i_degree_b;
    assign k_next   = r_k + PEXP_W'(1);
    // first exponent of the first polynomial that pairs with k_next
    assign i_lo_next = (k_next > PEXP_W'(r_db)) ? (k_next - PEXP_W'(r_db)) : '0;
    // last one for the current k
    assign i_hi      = (r_k < PEXP_W'(r_da)) ? r_k : PEXP_W'(r_da);

    always_comb begin
        n_state = r_state;
        n_da    = r_da;
        n_db    = r_db;
        n_total = r_total;
        n_k     = r_k;
        n_i     = r_i;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        o_cmd.addr_a = r_i;
        o_cmd.addr_b = EXP_W'(r_k - PEXP_W'(r_i));
        o_cmd.out_exp  = r_k;
        o_cmd.out_last = (r_k == r_total);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    case (i_op)
                        OP_LOAD_A: o_cmd.wr_a = 1'b1;
                        OP_LOAD_B: o_cmd.wr_b = 1'b1;
                        OP_MULTIPLY: begin
                            n_da    = da_clamp;
                            n_db    = db_clamp;
                            n_total = PEXP_W'(da_clamp) + PEXP_W'(db_clamp);
                            n_k     = '0;
                            n_i     = '0;
                            o_cmd.acc_clr = 1'b1;
                            n_state = S_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (PEXP_W'(r_i) == i_hi) begin
                    n_state = S_DRAIN;
                end else begin
                    n_i = r_i + EXP_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.acc_clr  = 1'b1;
                    if (r_k == r_total) begin
                        o_cmd.store_clr = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = k_next;
                        n_i     = EXP_W'(i_lo_next);
                        n_state = S_RUN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_da    <= n_da;
        r_db    <= n_db;
        r_total <= n_total;
        r_k     <= n_k;
        r_i     <= n_i;
    end

endmodule

// File: design/pm_dp.sv
// coefficient stores, multiply-accumulate pipeline, rounding and output register
// depends on pm_pkg
module pm_dp #(
    parameter int MAX_TERMS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pm_pkg::t_dp_cmd                 i_cmd,
    input  logic [pm_pkg::EXP_W-1:0]        i_exponent,
    input  logic signed [pm_pkg::COEF_W-1:0] i_coefficient,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [pm_pkg::PEXP_W-1:0]       o_out_exp,
    output logic signed [pm_pkg::COEF_W-1:0] o_out_coef,
    output logic                            o_out_last,
    output pm_pkg::t_dp_stat                o_stat
);
    import pm_pkg::*;

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    // 64-bit products, up to MAX_TERMS of them per sum
    localparam int ACC_W = PROD_W + IDX_W;
    localparam int SH_W  = ACC_W - 16;

    logic signed [COEF_W-1:0] r_mem_a [MAX_TERMS];
    logic signed [COEF_W-1:0] r_mem_b [MAX_TERMS];
    logic [MAX_TERMS-1:0]     r_va, r_vb;

    logic signed [COEF_W-1:0] r_a, r_b;
    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_out_valid;
    logic [PEXP_W-1:0]        r_out_exp;
    logic signed [COEF_W-1:0] r_out_coef;
    logic                     r_out_last;

    logic                     wr_ok;
    logic [IDX_W-1:0]         wr_idx, rd_a, rd_b;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic [SH_W-1:0]          shifted;
    logic                     ovf;
    logic signed [COEF_W-1:0] coef_sat;

    assign wr_ok  = {1'b0, i_exponent} < (EXP_W + 1)'(MAX_TERMS);
    assign wr_idx = i_exponent[IDX_W-1:0];
    assign rd_a   = i_cmd.addr_a[IDX_W-1:0];
    assign rd_b   = i_cmd.addr_b[IDX_W-1:0];

    // stores: data without reset, valid bits cleared by reset and after a multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && wr_ok) begin
            r_mem_a[wr_idx] <= i_coefficient;
        end
        if (i_cmd.wr_b && wr_ok) begin
            r_mem_b[wr_idx] <= i_coefficient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.store_clr) begin
            r_va <= '0;
            r_vb <= '0;
        end else begin
            if (i_cmd.wr_a && wr_ok) begin
                r_va[wr_idx] <= 1'b1;
            end
            if (i_cmd.wr_b && wr_ok) begin
                r_vb[wr_idx] <= 1'b1;
            end
        end
    end

    // read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_a    <= r_va[rd_a] ? r_mem_a[rd_a] : '0;
        r_b    <= r_vb[rd_b] ? r_mem_b[rd_b] : '0;
        r_prod <= r_a * r_b;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // round half up to q16.16 then saturate
    assign acc_rnd  = r_acc + ACC_W'(32'sd32768);
    assign shifted  = acc_rnd[ACC_W-1:16];
    assign ovf      = !((&shifted[SH_W-1:COEF_W-1]) || !(|shifted[SH_W-1:COEF_W-1]));
    assign coef_sat = !ovf ? shifted[COEF_W-1:0] :
                      (shifted[SH_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                       : {1'b0, {(COEF_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_exp  <= i_cmd.out_exp;
            r_out_coef <= coef_sat;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_exp       = r_out_exp;
    assign o_out_coef      = r_out_coef;
    assign o_out_last      = r_out_last;
    assign o_stat.busy     = r_v1 || r_v2;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

// File: design/polynomial_multiply.sv
// top level of the polynomial multiply block: stream ports, controller and datapath
// depends on pm_pkg, pm_ctrl and pm_dp
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  op, exponent, coefficient, degrees
//  m_axis    out        m_axis_tvalid / m_axis_tready  product exponent and coefficient, tlast
//
// op 3 is taken and dropped
// a multiply beat, with degrees clamped to MAX_TERMS-1, sends one coefficient pair per
// cycle through the single multiply-accumulate pipeline while the walk is running; the
// walk pauses for a read/multiply drain and a result load per product exponent
// each result waits in the output register; a stalled m_axis holds the walk before
// the next result is loaded, loads are taken again right after the last one is loaded
// reset is synchronous, active low, and marks both stores as all zero at once
module polynomial_multiply #(
    parameter int MAX_TERMS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // op[1:0], exponent[6:2], coefficient[38:7], degree_a[43:39], degree_b[48:44]
    input  logic [pm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // product_exponent[5:0], product_coefficient[37:6]
    output logic [pm_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // last_term
    output logic                             m_axis_tlast
);
    import pm_pkg::*;

    t_dp_cmd                  cmd;
    t_dp_stat                 stat;
    logic [OP_W-1:0]          in_op;
    logic [EXP_W-1:0]         in_exp;
    logic signed [COEF_W-1:0] in_coef;
    logic [DEG_W-1:0]         in_da, in_db;
    logic [PEXP_W-1:0]        out_exp;
    logic signed [COEF_W-1:0] out_coef;

    // unpack the input beat
    assign in_op   = s_axis_tdata[1:0];
    assign in_exp  = s_axis_tdata[6:2];
    assign in_coef = s_axis_tdata[38:7];
    assign in_da   = s_axis_tdata[43:39];
    assign in_db   = s_axis_tdata[48:44];

    pm_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (in_op),
        .i_degree_a (in_da),
        .i_degree_b (in_db),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pm_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_exponent    (in_exp),
        .i_coefficient (in_coef),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_exp     (out_exp),
        .o_out_coef    (out_coef),
        .o_out_last    (m_axis_tlast),
        .o_stat        (stat)
    );

    // pack the result beat, zero fill to whole bytes
    assign m_axis_tdata = {{(M_TDATA_W - PEXP_W - COEF_W){1'b0}}, out_coef, out_exp};

    // the input side only opens with the multiply pipeline empty
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !stat.busy)
        else $error("input ready while pairs are still in flight");

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    // stores are cleared only together with the last product term
    a_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.store_clr |-> (cmd.out_load && cmd.out_last))
        else $error("store clear outside the last result");

    // the input is ready again after the last term is loaded
    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && cmd.out_last) |=> s_axis_tready)
        else $error("controller did not return to idle after the last term");

endmodule
